FILE: rtl/core/ssnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnf_pkg: shared types and tables of the seven-segment number formatter
// Request and result structs, scaling constants, digit weight, segment and
// digit-select tables.
// ----------------------------------------------------------------------------
package ssnf_pkg;

  // Display geometry
  localparam int NumRows   = 3;
  localparam int NumDigits = 5;

  // Largest number that fits on five digits
  localparam logic [16:0] MaxShown = 17'd99999;
  localparam logic [7:0]  PointBit = 8'h80;

  // Autoscale thresholds (hundredths)
  localparam logic [23:0] LimitAsIs  = 24'd100000;
  localparam logic [23:0] LimitTenth = 24'd1000000;

  // Reciprocals: x/10 = (x * RecipTen) >> 26, x/100 = (x * RecipHundred) >> 32.
  // Exact for every x that does not end up saturated.
  localparam logic [25:0] RecipTen     = 26'd6710887;
  localparam logic [25:0] RecipHundred = 26'd42949673;

  // Digit positions
  localparam logic [2:0] PosLast  = 3'd4;
  localparam logic [2:0] PosPoint = 3'd2;
  localparam logic [2:0] PosTenth = 3'd3;

  // One request: the number and where to show it
  typedef struct packed {
    logic        func;
    logic [1:0]  row;
    logic [23:0] value;
  } ssnf_req_t;

  // One result: one digit of the display
  typedef struct packed {
    logic [4:0] row_select;
    logic [7:0] segments;
    logic [2:0] digit_position;
    logic       overflow;
    logic       last;
  } ssnf_rsp_t;

  // Decimal weight of a digit position, most significant first
  function automatic logic [16:0] digit_weight(input logic [2:0] pos);
    logic [16:0] w;
    case (pos)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

  // Seven-segment pattern of a decimal digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // Digit-select code per row and position
  function automatic logic [4:0] select_code(input logic [1:0] row, input logic [2:0] pos);
    logic [4:0] c;
    case (row)
      2'd0: begin
        case (pos)
          3'd0:    c = 5'h0E;
          3'd1:    c = 5'h16;
          3'd2:    c = 5'h06;
          3'd3:    c = 5'h1A;
          default: c = 5'h0A;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    c = 5'h12;
          3'd1:    c = 5'h02;
          3'd2:    c = 5'h1C;
          3'd3:    c = 5'h0C;
          default: c = 5'h14;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    c = 5'h04;
          3'd1:    c = 5'h18;
          3'd2:    c = 5'h08;
          3'd3:    c = 5'h10;
          default: c = 5'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/seven_segment_number_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_formatter: number to five seven-segment digits
// Scales (when func is low) and saturates a number, then emits its five digits, most
// significant first, each with the row's digit-select code.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | direction | per request
//  --------+--------------------------------------+-----------+------------
//  request | in_valid_i, in_stall_o, in_req_i     | in        | 1 item
//  result  | out_valid_o, out_stall_i, out_rsp_o  | out       | 5 items
//
//  A request sits in the input register, where the scaling multiply and
//  saturation run, then moves to the digit unit, which peels off one
//  decimal digit per cycle while the result is not stalled and registers
//  each digit into the result register. The next request is loaded into
//  the digit unit in the cycle its last digit leaves, so back-to-back
//  requests stream with no gap.
//  Reset clears all valid flags; a stalled result holds, and backs up the
//  digit unit and then the input register.

module seven_segment_number_formatter #(
  parameter int NumRows = ssnf_pkg::NumRows
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssnf_pkg::ssnf_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssnf_pkg::ssnf_rsp_t out_rsp_o
);

  // Input register
  logic                in_valid_q, in_valid_d;
  ssnf_pkg::ssnf_req_t in_q;

  // Digit unit
  logic        busy_q, busy_d;
  logic [2:0]  k_q, k_d;
  logic [16:0] rem_q, rem_d;
  logic [1:0]  row_q;
  logic        pt_en_q;
  logic [2:0]  pt_pos_q;
  logic        ovf_q;

  // Result register
  logic                out_valid_q, out_valid_d;
  ssnf_pkg::ssnf_rsp_t out_q, out_d;

  logic in_accept;
  logic adv;
  logic load;

  // Handshake and flow control
  assign adv       = busy_q && (!out_valid_q || !out_stall_i);
  assign load      = in_valid_q && (!busy_q || (adv && (k_q == ssnf_pkg::PosLast)));
  assign in_stall_o = in_valid_q && !load;
  assign in_accept = in_valid_i && !in_stall_o;

  assign in_valid_d = in_accept ? 1'b1 : (load ? 1'b0 : in_valid_q);

  // Scaling: pick reciprocal, multiply, select range, saturate
  logic [25:0] mul_k;
  logic [49:0] prod;
  logic [23:0] scaled;
  logic        pt_en_c;
  logic [2:0]  pt_pos_c;
  logic [16:0] shown;
  logic        ovf_c;
  logic [1:0]  row_c;

  assign mul_k = (in_q.value < ssnf_pkg::LimitTenth) ? ssnf_pkg::RecipTen
                                                     : ssnf_pkg::RecipHundred;
  assign prod  = {26'd0, in_q.value} * {24'd0, mul_k};

  always_comb begin
    scaled   = in_q.value;
    pt_en_c  = 1'b0;
    pt_pos_c = ssnf_pkg::PosPoint;
    if (!in_q.func) begin
      if (in_q.value < ssnf_pkg::LimitAsIs) begin
        pt_en_c  = 1'b1;
      end else if (in_q.value < ssnf_pkg::LimitTenth) begin
        scaled   = prod[49:26];
        pt_en_c  = 1'b1;
        pt_pos_c = ssnf_pkg::PosTenth;
      end else begin
        scaled   = {6'd0, prod[49:32]};
      end
    end
  end

  assign ovf_c = scaled > {7'd0, ssnf_pkg::MaxShown};
  assign shown = ovf_c ? ssnf_pkg::MaxShown : scaled[16:0];

  // Out-of-range rows fold onto the last row
  assign row_c = (32'(in_q.row) >= NumRows) ? 2'(NumRows - 1) : in_q.row;

  // Digit extraction: compare against the nine multiples of the weight
  logic [16:0] wt;
  logic [16:0] lim [10];
  logic [3:0]  digit;
  logic [7:0]  seg;

  assign wt = ssnf_pkg::digit_weight(k_q);

  always_comb begin
    lim[0] = 17'd0;
    for (int m = 1; m < 10; m++) begin
      lim[m] = 17'(17'(m) * wt);
    end
  end

  always_comb begin
    digit = 4'd0;
    for (int m = 1; m < 10; m++) begin
      if (rem_q >= lim[m]) begin
        digit = 4'(m);
      end
    end
  end

  always_comb begin
    seg = ssnf_pkg::seg_pattern(digit);
    if (pt_en_q && (k_q == pt_pos_q)) begin
      seg = seg | ssnf_pkg::PointBit;
    end
  end

  // Digit unit sequencing
  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    rem_d  = rem_q;
    if (adv) begin
      k_d   = k_q + 3'd1;
      rem_d = rem_q - lim[digit];
      if (k_q == ssnf_pkg::PosLast) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      k_d    = 3'd0;
      rem_d  = shown;
    end
  end

  // Result assembly
  always_comb begin
    out_d.row_select     = ssnf_pkg::select_code(row_q, k_q);
    out_d.segments       = seg;
    out_d.digit_position = k_q;
    out_d.overflow       = ovf_q;
    out_d.last           = (k_q == ssnf_pkg::PosLast);
  end

  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      busy_q      <= 1'b0;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      busy_q      <= busy_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
    rem_q <= rem_d;
    if (load) begin
      row_q    <= row_c;
      pt_en_q  <= pt_en_c;
      pt_pos_q <= pt_pos_c;
      ovf_q    <= ovf_c;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  // Position counter never runs past the last digit while busy
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (k_q <= ssnf_pkg::PosLast))
    else $error("digit position out of range");

  // Remainder always fits below ten times the current weight
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({3'd0, rem_q} < 20'(20'd10 * {3'd0, wt})))
    else $error("remainder exceeds digit range");

  // The unit stays busy until its last digit has gone out
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (k_q != ssnf_pkg::PosLast)) |=> busy_q)
    else $error("digit unit dropped a request early");

  // A saturated number never carries a decimal point
  a_ovf_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.overflow) |-> !out_q.segments[7])
    else $error("decimal point on saturated number");
`endif

endmodule
